// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types and constants for the calibration decode and the datapath.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH = 2'd2;

    localparam logic [7:0] READY_MASK = 8'h60;
    localparam logic signed [16:0] PRESS_BIAS = 17'sd16384;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_coef;

endpackage

// ===== rtl/bpc_calib.sv =====
// ----------------------------------------------------------------------------
// Calibration register file
// Holds the three packed calibration words and splits them into coefficients.
// ----------------------------------------------------------------------------
module bpc_calib import bpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_coef                 o_coef
);

    logic [CFG_DATA_W-1:0] r_cal_low;
    logic [CFG_DATA_W-1:0] r_cal_mid;
    logic [CFG_DATA_W-1:0] r_cal_high;
    logic [167:0]          w_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low <= '0;
            r_cal_mid <= '0;
            r_cal_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAL_LOW: r_cal_low <= i_cfg_wdata;
                REG_CAL_MID: r_cal_mid <= i_cfg_wdata;
                REG_CAL_HIGH: r_cal_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cal = {r_cal_high, r_cal_mid, r_cal_low};

    always_comb begin
        o_coef.t1 = w_cal[15:0];
        o_coef.t2 = w_cal[31:16];
        o_coef.t3 = $signed(w_cal[39:32]);
        o_coef.p1 = $signed(w_cal[55:40]);
        o_coef.p2 = $signed(w_cal[71:56]);
        o_coef.p3 = $signed(w_cal[79:72]);
        o_coef.p4 = $signed(w_cal[87:80]);
        o_coef.p5 = w_cal[103:88];
        o_coef.p6 = w_cal[119:104];
        o_coef.p7 = $signed(w_cal[127:120]);
        o_coef.p8 = $signed(w_cal[135:128]);
        o_coef.p9 = $signed(w_cal[151:136]);
        o_coef.p10 = $signed(w_cal[159:152]);
        o_coef.p11 = $signed(w_cal[167:160]);
    end

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure and temperature compensation
// Ten-stage pipeline evaluating the calibration polynomials for one sample.
// ----------------------------------------------------------------------------
// The input channel carries one item per sample: the status byte and the raw
// 24-bit pressure and temperature readings. The output channel returns one
// item per input: a status bit, the temperature in 1/65536 degC and the
// pressure in 1/64 Pa. A sample whose status lacks either data-ready bit
// returns status one with both values zero.
// The datapath is ten register stages deep. One item is accepted per cycle
// unless all stages are full and the output stalls; each multiplier in the
// chain is followed by its own register.
// Every stage has a valid bit, and a stage may load whenever it is empty or
// the stage after it moves, so bubbles are squeezed out and the input stays
// ready while the output waits, until all ten stages are full.
// The calibration words are written through the configuration port and are
// decoded into coefficients combinationally; write them only while idle.
// Synchronous reset clears the calibration words and all valid bits.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation import bpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_status_byte,
    input  logic [23:0]           i_raw_pressure,
    input  logic [23:0]           i_raw_temperature,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_result_status,
    output logic signed [23:0]    o_temperature_q16,
    output logic [23:0]           o_pressure_q6
);

    localparam int NSTG = 10;

    t_coef w_c;

    logic [NSTG:1] r_vld;
    logic [NSTG+1:1] w_en;

    // Stage 1
    logic              r_rdy1;
    logic [23:0]       r_rp1;
    logic signed [25:0] r_dt1;
    logic [30:0]       r_pp1;
    // Stage 2
    logic              r_rdy2;
    logic [23:0]       r_rp2;
    logic [30:0]       r_pp2;
    logic signed [42:0] r_ma2;
    logic signed [51:0] r_mb2;
    logic [54:0]       r_ppr2;
    // Stage 3
    logic              r_rdy3;
    logic [23:0]       r_rp3;
    logic [30:0]       r_pp3;
    logic signed [42:0] r_ma3;
    logic signed [59:0] r_mc3;
    logic signed [63:0] r_nl23;
    // Stage 4
    logic              r_rdy4;
    logic [23:0]       r_rp4;
    logic [30:0]       r_pp4;
    logic signed [63:0] r_nl24;
    logic signed [23:0] r_tq4;
    // Stage 5
    logic              r_rdy5;
    logic [23:0]       r_rp5;
    logic [30:0]       r_pp5;
    logic signed [63:0] r_nl25;
    logic signed [23:0] r_tq5;
    logic signed [47:0] r_t25;
    logic signed [40:0] r_m65;
    logic signed [40:0] r_m25;
    logic signed [33:0] r_q5;
    // Stage 6
    logic              r_rdy6;
    logic [23:0]       r_rp6;
    logic signed [63:0] r_nl26;
    logic signed [23:0] r_tq6;
    logic signed [40:0] r_m66;
    logic signed [40:0] r_m26;
    logic signed [55:0] r_t36;
    logic signed [55:0] r_m76;
    logic signed [55:0] r_m36;
    logic signed [65:0] r_nl16;
    // Stage 7
    logic              r_rdy7;
    logic [23:0]       r_rp7;
    logic signed [63:0] r_nl27;
    logic signed [65:0] r_nl17;
    logic signed [23:0] r_tq7;
    logic signed [63:0] r_m87;
    logic signed [63:0] r_m47;
    logic signed [39:0] r_offa7;
    logic signed [39:0] r_sensa7;
    // Stage 8
    logic              r_rdy8;
    logic [23:0]       r_rp8;
    logic signed [23:0] r_tq8;
    logic signed [41:0] r_off8;
    logic signed [41:0] r_sens8;
    logic signed [36:0] r_nl8;
    // Stage 9
    logic              r_rdy9;
    logic signed [23:0] r_tq9;
    logic signed [41:0] r_off9;
    logic signed [36:0] r_nl9;
    logic signed [62:0] r_sp9;
    // Stage 10
    logic              r_st10;
    logic signed [23:0] r_tq10;
    logic [23:0]       r_pq10;

    logic signed [61:0] w_tn;
    logic signed [62:0] w_tsum;
    logic signed [30:0] w_tr;
    logic signed [23:0] w_tq;
    logic signed [43:0] w_sum;
    logic signed [44:0] w_psum;
    logic signed [34:0] w_pr;
    logic [23:0]       w_pq;
    logic signed [16:0] w_p1b;
    logic signed [16:0] w_p2b;

    bpc_calib u_calib (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coef      (w_c)
    );

    always_comb begin
        w_en[NSTG+1] = i_ready;
        for (int k = NSTG; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_p1b = 17'(w_c.p1) - PRESS_BIAS;
    assign w_p2b = 17'(w_c.p2) - PRESS_BIAS;

    always_comb begin
        w_tn = (62'(r_ma3) <<< 18) + 62'(r_mc3);
        w_tsum = 63'(w_tn) + 63'sd2147483648;
        w_tr = w_tsum[62:32];
        priority if (w_tr > 31'sd8388607) begin
            w_tq = 24'sh7FFFFF;
        end else if (w_tr < -31'sd8388608) begin
            w_tq = 24'sh800000;
        end else begin
            w_tq = w_tr[23:0];
        end
    end

    always_comb begin
        w_sum = 44'(r_off9) + 44'(r_sp9 >>> 24) + 44'(r_nl9);
        w_psum = 45'(w_sum) + 45'sd512;
        w_pr = w_psum[44:10];
        priority if (w_pr < 35'sd0) begin
            w_pq = '0;
        end else if (w_pr > 35'sd16777215) begin
            w_pq = 24'hFFFFFF;
        end else begin
            w_pq = w_pr[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_rdy1 <= (i_status_byte & READY_MASK) == READY_MASK;
            r_rp1 <= i_raw_pressure;
            r_dt1 <= $signed({2'b00, i_raw_temperature}) - $signed({2'b00, w_c.t1, 8'h00});
            r_pp1 <= 31'((48'(i_raw_pressure) * 48'(i_raw_pressure)) >> 17);
        end
        if (w_en[2]) begin
            r_rdy2 <= r_rdy1;
            r_rp2 <= r_rp1;
            r_pp2 <= r_pp1;
            r_ma2 <= 43'(r_dt1) * 43'($signed({1'b0, w_c.t2}));
            r_mb2 <= 52'(r_dt1) * 52'(r_dt1);
            r_ppr2 <= 55'(r_pp1) * 55'(r_rp1);
        end
        if (w_en[3]) begin
            r_rdy3 <= r_rdy2;
            r_rp3 <= r_rp2;
            r_pp3 <= r_pp2;
            r_ma3 <= r_ma2;
            r_mc3 <= 60'(r_mb2) * 60'(w_c.t3);
            r_nl23 <= 64'($signed({1'b0, r_ppr2})) * 64'(w_c.p11);
        end
        if (w_en[4]) begin
            r_rdy4 <= r_rdy3;
            r_rp4 <= r_rp3;
            r_pp4 <= r_pp3;
            r_nl24 <= r_nl23;
            r_tq4 <= w_tq;
        end
        if (w_en[5]) begin
            r_rdy5 <= r_rdy4;
            r_rp5 <= r_rp4;
            r_pp5 <= r_pp4;
            r_nl25 <= r_nl24;
            r_tq5 <= r_tq4;
            r_t25 <= 48'(r_tq4) * 48'(r_tq4);
            r_m65 <= 41'($signed({1'b0, w_c.p6})) * 41'(r_tq4);
            r_m25 <= 41'(w_p2b) * 41'(r_tq4);
            r_q5 <= (34'(w_c.p9) <<< 16) + 34'(w_c.p10) * 34'(r_tq4);
        end
        if (w_en[6]) begin
            r_rdy6 <= r_rdy5;
            r_rp6 <= r_rp5;
            r_nl26 <= r_nl25;
            r_tq6 <= r_tq5;
            r_m66 <= r_m65;
            r_m26 <= r_m25;
            r_t36 <= 56'($signed(r_t25[47:16])) * 56'(r_tq5);
            r_m76 <= 56'(w_c.p7) * 56'(r_t25);
            r_m36 <= 56'(w_c.p3) * 56'(r_t25);
            r_nl16 <= 66'($signed({1'b0, r_pp5})) * 66'(r_q5);
        end
        if (w_en[7]) begin
            r_rdy7 <= r_rdy6;
            r_rp7 <= r_rp6;
            r_nl27 <= r_nl26;
            r_nl17 <= r_nl16;
            r_tq7 <= r_tq6;
            r_m87 <= 64'(w_c.p8) * 64'(r_t36);
            r_m47 <= 64'(w_c.p4) * 64'(r_t36);
            r_offa7 <= (40'($signed({1'b0, w_c.p5})) <<< 19) + 40'(r_m66 >>> 6)
                     + 40'(r_m76 >>> 24);
            r_sensa7 <= (40'(w_p1b) <<< 20) + 40'(r_m26 >>> 5) + 40'(r_m36 >>> 24);
        end
        if (w_en[8]) begin
            r_rdy8 <= r_rdy7;
            r_rp8 <= r_rp7;
            r_tq8 <= r_tq7;
            r_off8 <= 42'(r_offa7) + 42'(r_m87 >>> 31);
            r_sens8 <= 42'(r_sensa7) + 42'(r_m47 >>> 29);
            r_nl8 <= 37'(r_nl17 >>> 31) + 37'(r_nl27 >>> 32);
        end
        if (w_en[9]) begin
            r_rdy9 <= r_rdy8;
            r_tq9 <= r_tq8;
            r_off9 <= r_off8;
            r_nl9 <= r_nl8;
            r_sp9 <= 63'($signed(r_sens8[37:0])) * 63'($signed({1'b0, r_rp8}));
        end
        if (w_en[10]) begin
            r_st10 <= !r_rdy9;
            r_tq10 <= r_rdy9 ? r_tq9 : '0;
            r_pq10 <= r_rdy9 ? w_pq : '0;
        end
    end

    assign o_valid = r_vld[NSTG];
    assign o_result_status = r_st10;
    assign o_temperature_q16 = r_tq10;
    assign o_pressure_q6 = r_pq10;

`ifndef SYNTHESIS
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_status |-> o_temperature_q16 == '0 && o_pressure_q6 == '0)
        else $error("Not-ready result carries nonzero values.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("Output valid right after reset.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_vld == '1)
        else $error("Input stalled while the pipeline has a free stage.");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_pq10) && $stable(r_tq10))
        else $error("Stalled result changed.");
`endif

endmodule

// ===== tb/baro_pressure_temp_compensation_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw sensor samples under several calibration sets and compares each
// compensated result against a predicted temperature and pressure.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_test import bpc_pkg::*; ();

    localparam int CAL_WORDS = 3;

    typedef struct {
        logic        status;
        logic [23:0] temp_q16;
        logic [23:0] press_q6;
    } t_reading;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [7:0]            i_status_byte;
    logic [23:0]           i_raw_pressure;
    logic [23:0]           i_raw_temperature;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_result_status;
    logic signed [23:0]    o_temperature_q16;
    logic [23:0]           o_pressure_q6;

    baro_pressure_temp_compensation dut (.*);

    logic [55:0] cal_word [CAL_WORDS];
    t_reading    pending_readings[$];
    int          mismatch_count;
    int          result_count;
    int          sample_count;
    int          not_ready_count;
    int          cycle_count;
    int          hold_cycles;
    bit          stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic int unsigned cal_byte(int k);
        return 32'((cal_word[k / 7] >> (8 * (k % 7))) & 56'hFF);
    endfunction

    function automatic longint cal_u16(int k);
        return longint'(cal_byte(k) | (cal_byte(k + 1) << 8));
    endfunction

    function automatic longint cal_s16(int k);
        return longint'(16'(cal_u16(k)) ^ 16'h8000) - 32768;
    endfunction

    function automatic longint cal_s8(int k);
        return longint'(cal_byte(k) ^ 8'h80) - 128;
    endfunction

    function automatic t_reading compensate(logic [7:0] st, logic [23:0] rp_in,
                                            logic [23:0] rt_in);
        t_reading r;
        longint rp, rt, dt, tn, tq, t2, t3, off, sens, sterm, pp, q, nl, sum, pq;
        r.status = 1'b1;
        r.temp_q16 = '0;
        r.press_q6 = '0;
        if ((st & READY_MASK) != READY_MASK) return r;
        rp = longint'(rp_in);
        rt = longint'(rt_in);
        dt = rt - cal_u16(0) * 256;
        tn = dt * cal_u16(2) * 262144 + dt * dt * cal_s8(4);
        tq = floor_shift(tn + 64'sd2147483648, 32);
        if (tq > 8388607) tq = 8388607;
        if (tq < -8388608) tq = -8388608;
        t2 = tq * tq;
        t3 = floor_shift(t2, 16) * tq;
        off = cal_u16(11) * 524288 + floor_shift(cal_u16(13) * tq, 6)
            + floor_shift(cal_s8(15) * t2, 24) + floor_shift(cal_s8(16) * t3, 31);
        sens = (cal_s16(5) - 16384) * 1048576 + floor_shift((cal_s16(7) - 16384) * tq, 5)
             + floor_shift(cal_s8(9) * t2, 24) + floor_shift(cal_s8(10) * t3, 29);
        sterm = floor_shift(sens * rp, 24);
        pp = (rp * rp) >>> 17;
        q = cal_s16(17) * 65536 + cal_s8(19) * tq;
        nl = floor_shift(pp * q, 31) + floor_shift(pp * rp * cal_s8(20), 32);
        sum = off + sterm + nl;
        pq = floor_shift(sum + 512, 10);
        if (pq < 0) pq = 0;
        if (pq > 16777215) pq = 16777215;
        r.status = 1'b0;
        r.temp_q16 = tq[23:0];
        r.press_q6 = pq[23:0];
        return r;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        int gap;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else if (stall_enable) begin
                gap = gap_length();
                i_ready <= (gap == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count <= result_count + 1;
            if (pending_readings.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10) $display("Unexpected result item.");
            end else begin
                want = pending_readings.pop_front();
                if (want.status !== o_result_status || want.temp_q16 !== o_temperature_q16
                    || want.press_q6 !== o_pressure_q6) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %0d %h %h, got %0d %h %h",
                                 want.status, want.temp_q16, want.press_q6,
                                 o_result_status, o_temperature_q16, o_pressure_q6);
                end
            end
        end
    end

    task automatic send_sample(logic [7:0] st, logic [23:0] rp, logic [23:0] rt);
        int gap;
        gap = stall_enable ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_status_byte <= st;
        i_raw_pressure <= rp;
        i_raw_temperature <= rt;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(compensate(st, rp, rt));
        sample_count++;
        if ((st & READY_MASK) != READY_MASK) not_ready_count++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_calibration(logic [55:0] low, logic [55:0] mid, logic [55:0] high);
        logic [55:0] vals [CAL_WORDS];
        logic [CFG_IDX_W-1:0] idx [CAL_WORDS];
        vals = '{low, mid, high};
        idx = '{REG_CAL_LOW, REG_CAL_MID, REG_CAL_HIGH};
        for (int i = 0; i < CAL_WORDS; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            cal_word[i] = vals[i];
        end
        // An index past the last register must leave the calibration alone.
        i_cfg_idx <= CFG_IDX_W'(CAL_WORDS);
        i_cfg_wdata <= 56'({$urandom, $urandom});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [55:0] random_word();
        return 56'({$urandom, $urandom});
    endfunction

    // Typical calibration: realistic T1 and T2 in the low word; T3 and P1 are random.
    function automatic logic [55:0] typical_low();
        logic [15:0] t1, t2, p1;
        logic [7:0] t3;
        t1 = 16'($urandom_range(26000, 28000));
        t2 = 16'($urandom_range(18000, 20000));
        t3 = 8'($urandom_range(0, 255));
        p1 = 16'($urandom_range(0, 65535));
        return {p1, t3, t2, t1};
    endfunction

    task automatic test_directed();
        write_calibration(typical_low(), random_word(), random_word());
        send_sample(8'h00, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(8'h20, 24'h6B0000, 24'h7F0000);
        send_sample(8'h40, 24'h6B0000, 24'h7F0000);
        send_sample(8'hFF, 24'h000000, 24'h000000);
        send_sample(8'h60, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(8'h60, 24'h6B2F00, 24'h6A0000);
        send_sample(8'h9F, 24'h123456, 24'h654321);
        send_sample(8'h7F, 24'h800000, 24'h800000);
        wait_idle();
        write_calibration('1, '1, '1);
        send_sample(8'h60, 24'hFFFFFF, 24'h000000);
        send_sample(8'h60, 24'h000000, 24'hFFFFFF);
        send_sample(8'hE0, 24'h7FFFFF, 24'h7FFFFF);
        wait_idle();
        write_calibration('0, '0, '0);
        send_sample(8'h60, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(8'h60, 24'h000001, 24'h000001);
        wait_idle();
        // Large T2 and T3 drive the temperature past both rails.
        write_calibration({16'h0, 8'h7F, 16'hFFFF, 16'h0000}, random_word(), random_word());
        send_sample(8'h60, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(8'h60, 24'h400000, 24'h000000);
        wait_idle();
        write_calibration({16'h0, 8'h80, 16'hFFFF, 16'hFFFF}, random_word(), random_word());
        send_sample(8'h60, 24'hFFFFFF, 24'h000000);
        send_sample(8'h60, 24'h800000, 24'hFFFFFF);
        wait_idle();
    endtask

    task automatic test_random_samples(int phases, int per_phase);
        logic [7:0] st;
        for (int p = 0; p < phases; p++) begin
            if (p % 3 == 0) write_calibration(random_word(), random_word(), random_word());
            else write_calibration(typical_low(), random_word(), random_word());
            for (int i = 0; i < per_phase; i++) begin
                st = 8'($urandom);
                if ($urandom_range(0, 4) != 0) st = st | READY_MASK;
                send_sample(st, 24'($urandom), 24'($urandom));
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        write_calibration(typical_low(), random_word(), random_word());
        hold_cycles = 60;
        for (int i = 0; i < 30; i++) send_sample(8'h60, 24'($urandom), 24'($urandom));
        wait_idle();
    endtask

    task automatic test_full_rate();
        stall_enable = 1'b0;
        write_calibration(typical_low(), random_word(), random_word());
        for (int i = 0; i < 40; i++)
            send_sample(8'h60 | 8'($urandom), 24'($urandom), 24'($urandom));
        wait_idle();
        stall_enable = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_status_byte = '0;
        i_raw_pressure = '0;
        i_raw_temperature = '0;
        mismatch_count = 0;
        result_count = 0;
        sample_count = 0;
        not_ready_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        stall_enable = 1'b1;
        for (int i = 0; i < CAL_WORDS; i++) cal_word[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset calibration is all zero.
        send_sample(8'h60, 24'h123456, 24'h654321);
        wait_idle();
        test_directed();
        test_backpressure();
        test_full_rate();
        test_random_samples(8, 40);
        wait_idle();
        $display("Sent %0d samples (%0d not ready) over several calibration sets.",
                 sample_count, not_ready_count);
        $display("Checked %0d results, %0d mismatches.", result_count, mismatch_count);
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== baro_pressure_temp_compensation.f =====
rtl/bpc_pkg.sv
rtl/bpc_calib.sv
rtl/baro_pressure_temp_compensation.sv
tb/baro_pressure_temp_compensation_test.sv
